### src/mfbp_pkg.sv
// Package with the shared types and constants of the MSB-first bit packer.
package mfbp_pkg;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned CODE_BITS   = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_ALIGN = 2'd1,
    ACT_FLUSH = 2'd2
  } action_e;

  typedef enum logic {
    CMD_BITS  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_MOD,
    FRONT_PUSH
  } front_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] value;
    logic [5:0]  bit_count;
    logic [7:0]  align_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last;
  } out_item_t;

  typedef struct packed {
    cmd_e        kind;
    logic [31:0] value;
    logic [7:0]  count;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

### src/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer.
// Codes are packed most significant bit first into bytes, each byte being offered as a
// transfer as soon as it is complete, with last set on the final byte that an item
// produces. The front part accepts an add or flush item while the queue is not full;
// an align item stalls the input while the remainder of the bit position is found one
// quotient bit per cycle, and, when padding is needed, while the queue is full. A queue
// of QueueDepth commands lets the back part work on its own: it loads a command and
// then turns out one output byte or partial byte per cycle while the output is not
// stalled.
module msb_first_bit_packer
  import mfbp_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  queue_status_t queue_status;
  logic          push;
  cmd_t          push_data;
  logic          pop;
  cmd_t          head;

  mfbp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .queue_status_i (queue_status),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  mfbp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (queue_status)
  );

  mfbp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .queue_status_i (queue_status),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

### src/mfbp_fifo.sv
// Short command queue between the front and back parts of the bit packer.
module mfbp_fifo
  import mfbp_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmd_t          push_data_i,
  input  logic          pop_i,
  output cmd_t          head_o,
  output queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign status_o.valid = (cnt_q != '0);
  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign head_o         = mem_q[rd_ptr_q];

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/mfbp_front.sv
// Front part of the bit packer: accepts items, tracks the bit position and works out padding.
module mfbp_front
  import mfbp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_item_t      in_data_i,
  input  queue_status_t queue_status_i,
  output logic          push_o,
  output cmd_t          push_data_o
);

  front_state_e state_q, state_d;
  logic [31:0]  pos_q, pos_d;
  logic [31:0]  div_q, div_d;
  logic [7:0]   rem_q, rem_d;
  logic [7:0]   gran_q, gran_d;
  logic [7:0]   pad_q, pad_d;
  logic [4:0]   step_q, step_d;
  logic         accept;
  logic [5:0]   cnt_sat;
  logic [8:0]   trial;
  logic [7:0]   rem_next;

  assign accept  = in_valid_i && !in_stall_o;
  assign cnt_sat = (in_data_i.bit_count > 6'(CODE_BITS)) ? 6'(CODE_BITS) : in_data_i.bit_count;

  assign trial    = {rem_q, div_q[31]};
  assign rem_next = (trial >= {1'b0, gran_q}) ? 8'(trial - {1'b0, gran_q}) : trial[7:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FRONT_IDLE: begin
        if (accept && (in_data_i.action == ACT_ALIGN)) begin
          state_d = FRONT_MOD;
        end
      end
      FRONT_MOD: begin
        if (step_q == 5'd31) begin
          state_d = FRONT_PUSH;
        end
      end
      FRONT_PUSH: begin
        if ((pad_q == '0) || !queue_status_i.full) begin
          state_d = FRONT_IDLE;
        end
      end
      default: state_d = FRONT_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    push_o      = 1'b0;
    push_data_o = '{kind: CMD_BITS, value: '0, count: '0};
    pos_d       = pos_q;
    div_d       = div_q;
    rem_d       = rem_q;
    gran_d      = gran_q;
    pad_d       = pad_q;
    step_d      = step_q;
    unique case (state_q)
      FRONT_IDLE: begin
        in_stall_o = queue_status_i.full;
        if (accept) begin
          unique case (in_data_i.action)
            ACT_ADD: begin
              push_o      = (cnt_sat != '0);
              push_data_o = '{kind: CMD_BITS, value: in_data_i.value, count: 8'(cnt_sat)};
              pos_d       = pos_q + 32'(cnt_sat);
            end
            ACT_ALIGN: begin
              div_d  = pos_q;
              rem_d  = '0;
              step_d = '0;
              gran_d = (in_data_i.align_bits == '0) ? 8'd1 : in_data_i.align_bits;
            end
            ACT_FLUSH: begin
              push_o      = 1'b1;
              push_data_o = '{kind: CMD_FLUSH, value: '0, count: '0};
              pos_d       = '0;
            end
            default: begin
            end
          endcase
        end
      end
      FRONT_MOD: begin
        rem_d  = rem_next;
        div_d  = {div_q[30:0], 1'b0};
        step_d = step_q + 1'b1;
        pad_d  = (rem_next != '0) ? gran_q - rem_next : '0;
      end
      FRONT_PUSH: begin
        if ((pad_q != '0) && !queue_status_i.full) begin
          push_o      = 1'b1;
          push_data_o = '{kind: CMD_BITS, value: '0, count: pad_q};
          pos_d       = pos_q + 32'(pad_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
      pos_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    rem_q  <= rem_d;
    gran_q <= gran_d;
    pad_q  <= pad_d;
  end

endmodule

### src/mfbp_back.sv
// Back part of the bit packer: shifts command bits into bytes and drives the output register.
module mfbp_back
  import mfbp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  queue_status_t queue_status_i,
  input  cmd_t          head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output out_item_t     out_data_o
);

  logic        busy_q, busy_d;
  cmd_e        kind_q, kind_d;
  logic [7:0]  rem_q, rem_d;
  logic [31:0] val_q, val_d;
  logic [6:0]  pend_q, pend_d;
  logic [2:0]  pcnt_q, pcnt_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;
  logic        can_go;
  logic [3:0]  room;
  logic [3:0]  take;
  logic [3:0]  fill;
  logic [15:0] merged;
  logic [7:0]  rem_left;
  logic [7:0]  load_shift;

  assign can_go     = !out_valid_q || !out_stall_i;
  assign pop_o      = !busy_q && queue_status_i.valid;
  assign room       = 4'(BYTE_BITS) - {1'b0, pcnt_q};
  assign take       = (rem_q < {4'b0, room}) ? rem_q[3:0] : room;
  assign fill       = {1'b0, pcnt_q} + take;
  assign merged     = {1'b0, pend_q, val_q[31:24]} << take;
  assign rem_left   = rem_q - {4'b0, take};
  assign load_shift = 8'(CODE_BITS) - head_i.count;

  always_comb begin
    busy_d      = busy_q;
    kind_d      = kind_q;
    rem_d       = rem_q;
    val_d       = val_q;
    pend_d      = pend_q;
    pcnt_d      = pcnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (pop_o) begin
      busy_d = 1'b1;
      kind_d = head_i.kind;
      rem_d  = head_i.count;
      val_d  = head_i.value << load_shift;
    end else if (busy_q && can_go) begin
      unique case (kind_q)
        CMD_FLUSH: begin
          if (pcnt_q != '0) begin
            out_valid_d         = 1'b1;
            out_data_d.byte_out = 8'({1'b0, pend_q} << (4'(BYTE_BITS) - {1'b0, pcnt_q}));
            out_data_d.last     = 1'b1;
          end
          pend_d = '0;
          pcnt_d = '0;
          busy_d = 1'b0;
        end
        CMD_BITS: begin
          val_d  = val_q << take;
          rem_d  = rem_left;
          busy_d = (rem_left != '0);
          if (fill == 4'(BYTE_BITS)) begin
            out_valid_d         = 1'b1;
            out_data_d.byte_out = merged[15:8];
            out_data_d.last     = (rem_left < 8'(BYTE_BITS));
            pend_d              = '0;
            pcnt_d              = '0;
          end else begin
            pend_d = merged[14:8];
            pcnt_d = fill[2:0];
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_q      <= '0;
      pcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pend_q      <= pend_d;
      pcnt_q      <= pcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    rem_q      <= rem_d;
    val_q      <= val_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### dv/msb_first_bit_packer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the MSB-first bit packer: directed table, then random transfers.
module testbench;
  import mfbp_pkg::*;

  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam int          PREDICT     = -1;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned END_DRAIN   = 200;
  localparam int unsigned WATCHDOG    = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    in_item_t    item;
    int          n_typed;
    logic [31:0] typed_bytes;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic [6:0]  acc_bits   = '0;
  logic [2:0]  acc_count  = '0;
  logic [31:0] stream_pos = '0;
  logic [7:0]  packed_bytes[$];
  out_item_t   expected_bytes[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  msb_first_bit_packer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #1 clk = ~clk;

  function automatic void shift_in_bit(input logic b);
    logic [7:0] acc;
    acc = {acc_bits, b};
    stream_pos = stream_pos + 32'd1;
    if (acc_count == 3'd7) begin
      packed_bytes.push_back(acc);
      acc_bits  = '0;
      acc_count = '0;
    end else begin
      acc_bits  = acc[6:0];
      acc_count = acc_count + 3'd1;
    end
  endfunction

  function automatic void predict_item(input in_item_t it);
    int          n_bits;
    int unsigned granule;
    int unsigned rem;
    int unsigned pad;
    logic [15:0] wide;
    packed_bytes.delete();
    case (it.action)
      ACT_ADD: begin
        n_bits = (it.bit_count > CODE_BITS) ? CODE_BITS : it.bit_count;
        for (int i = n_bits; i > 0; i--) shift_in_bit(it.value[i-1]);
      end
      ACT_ALIGN: begin
        granule = (it.align_bits == 8'd0) ? 1 : it.align_bits;
        rem = stream_pos % granule;
        pad = (rem != 0) ? granule - rem : 0;
        repeat (pad) shift_in_bit(1'b0);
      end
      ACT_FLUSH: begin
        if (acc_count != 3'd0) begin
          wide = {9'd0, acc_bits} << (BYTE_BITS - acc_count);
          packed_bytes.push_back(wide[7:0]);
        end
        acc_bits   = '0;
        acc_count  = '0;
        stream_pos = '0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic stim_row_t row(input logic [1:0] act, input logic [31:0] value,
                                    input logic [5:0] count, input logic [7:0] granule,
                                    input int n_typed, input logic [31:0] typed_bytes);
    stim_row_t r;
    r.item.action     = act;
    r.item.value      = value;
    r.item.bit_count  = count;
    r.item.align_bits = granule;
    r.n_typed         = n_typed;
    r.typed_bytes     = typed_bytes;
    return r;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned gsel;
    pick = $urandom_range(99);
    gsel = $urandom_range(99);
    it.value = $urandom();
    it.bit_count = ($urandom_range(99) < 8) ? 6'($urandom_range(63, 33))
                                            : 6'($urandom_range(32));
    if (gsel < 5) begin
      it.align_bits = 8'd0;
    end else if (gsel < 80) begin
      it.align_bits = 8'($urandom_range(16, 1));
    end else begin
      it.align_bits = 8'($urandom_range(255, 17));
    end
    if (pick < 62) begin
      it.action = ACT_ADD;
    end else if (pick < 78) begin
      it.action = ACT_ALIGN;
    end else if (pick < 94) begin
      it.action = ACT_FLUSH;
    end else begin
      it.action = ACT_UNUSED;
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input in_item_t it, input int n_typed, input logic [31:0] typed_bytes);
    out_item_t next_byte;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
    if (n_typed != PREDICT) begin
      packed_bytes.delete();
      for (int k = 0; k < n_typed; k++) packed_bytes.push_back(typed_bytes[31-8*k -: 8]);
    end
    for (int k = 0; k < packed_bytes.size(); k++) begin
      next_byte.byte_out = packed_bytes[k];
      next_byte.last     = (k == packed_bytes.size() - 1);
      expected_bytes.push_back(next_byte);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected byte %02h last %0b", out_data.byte_out, out_data.last);
        end
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.byte_out !== want.byte_out || out_data.last !== want.last) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                     want.byte_out, want.last, out_data.byte_out, out_data.last);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    stim_row_t   directed_rows[$];
    in_item_t    it;
    int unsigned sent;
    int unsigned phase_items;

    directed_rows = '{
      row(ACT_ADD,    32'hFFFF_FFFF, 6'd32, 8'd1,   4,       32'hFFFF_FFFF),
      row(ACT_ADD,    32'h0000_0000, 6'd32, 8'd1,   4,       32'h0000_0000),
      row(ACT_ADD,    32'h0000_00A5, 6'd8,  8'd1,   1,       32'hA500_0000),
      row(ACT_ADD,    32'h1234_5678, 6'd0,  8'd1,   0,       32'h0),
      row(ACT_ADD,    32'hFFFF_FFFF, 6'd63, 8'd1,   4,       32'hFFFF_FFFF),
      row(ACT_FLUSH,  32'h0,         6'd0,  8'd0,   0,       32'h0),
      row(ACT_ADD,    32'h0000_0005, 6'd3,  8'd1,   0,       32'h0),
      row(ACT_FLUSH,  32'h0,         6'd0,  8'd0,   1,       32'hA000_0000),
      row(ACT_ADD,    32'h0000_0001, 6'd1,  8'd1,   0,       32'h0),
      row(ACT_ALIGN,  32'h0,         6'd0,  8'd8,   1,       32'h8000_0000),
      row(ACT_ALIGN,  32'h0,         6'd0,  8'd8,   0,       32'h0),
      row(ACT_ALIGN,  32'h0,         6'd0,  8'd0,   0,       32'h0),
      row(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63, 8'd255, 0,       32'h0),
      row(ACT_ADD,    32'h0000_0003, 6'd2,  8'd1,   PREDICT, 32'h0),
      row(ACT_ALIGN,  32'h0,         6'd0,  8'd255, PREDICT, 32'h0),
      row(ACT_ALIGN,  32'h0,         6'd0,  8'd1,   PREDICT, 32'h0),
      row(ACT_ADD,    32'hDEAD_BEEF, 6'd32, 8'd1,   PREDICT, 32'h0),
      row(ACT_ALIGN,  32'h0,         6'd0,  8'd3,   PREDICT, 32'h0),
      row(ACT_ADD,    32'h0000_0001, 6'd33, 8'd1,   PREDICT, 32'h0),
      row(ACT_FLUSH,  32'h0,         6'd0,  8'd0,   PREDICT, 32'h0),
      row(ACT_ADD,    32'hFFFF_FFFF, 6'd7,  8'd1,   0,       32'h0),
      row(ACT_FLUSH,  32'h0,         6'd0,  8'd0,   1,       32'hFE00_0000),
      row(ACT_ALIGN,  32'h0,         6'd0,  8'd255, 0,       32'h0),
      row(ACT_ADD,    32'h8000_0000, 6'd32, 8'd1,   4,       32'h8000_0000),
      row(ACT_ALIGN,  32'h0,         6'd0,  8'd5,   PREDICT, 32'h0)
    };

    tx_idle_pct = 37;
    rx_idle_pct = 64;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].item, directed_rows[r].n_typed, directed_rows[r].typed_bytes);
    end
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 37;
          rx_idle_pct = 64;
          phase_items = 100;
        end
        1: begin
          tx_idle_pct = 64;
          rx_idle_pct = 37;
          phase_items = 100;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          phase_items = 105;
          hold_req    = hold_req + 1;
        end
      endcase
      sent = 0;
      while (sent < phase_items) begin
        it = random_item();
        send_item(it, PREDICT, 32'h0);
        if (it.action != ACT_UNUSED) sent++;
      end
      wait_drained();
    end

    repeat (END_DRAIN) @(posedge clk);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
